[hw/rtl/trcg_pkg.sv]
// Package for the tristate remote code generator: descriptor type, symbol
// patterns, register indexes and default parameter values.
// No dependencies.
package trcg_pkg;

    localparam int SYMBOLS_PER_FRAME_DEF = 16;
    localparam int FRAMES_DEF            = 3;
    localparam int CHANNELS_DEF          = 4;
    localparam int MAX_CODE_SYMBOLS_DEF  = 12;

    localparam int BUS_W            = 4;
    localparam int SLOTS_PER_SYMBOL = 8;
    localparam int SUB_W            = 3;
    localparam int WORD_W           = 24;
    localparam int LEN_W            = 4;
    localparam int KIND_W           = 2;
    localparam int S_TDATA_W        = 40;
    localparam int M_TDATA_W        = 8;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;

    localparam logic [BUS_W-1:0] ENABLE_RST = 4'hF;
    localparam logic [BUS_W-1:0] FORCE_RST  = 4'h0;

    // register index, taken from paddr[2]
    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_FORCE  = 1'b1;

    // item kinds on s_tuser
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // code modes
    localparam logic [KIND_W-1:0] CM_TRISTATE    = 2'd0;
    localparam logic [KIND_W-1:0] CM_SLOT_SQUARE = 2'd1;

    typedef struct packed {
        logic [KIND_W-1:0] code_mode;
        logic [LEN_W-1:0]  code_length;
        logic [WORD_W-1:0] code_word;
    } desc_t;

    // slot n of a symbol period is bit n
    localparam logic [SLOTS_PER_SYMBOL-1:0] TRI_PATTERN [4] = '{
        8'h11, 8'h77, 8'h71, 8'h17
    };

endpackage

[hw/rtl/tristate_remote_code_generator.sv]
// Tristate remote code generator. One item per clock cycle, sustained: a tick
// item reads one descriptor per channel from small per-channel register files
// (indexed by the frame counter), forms the bus sample and lands it in the
// output register at the accepting edge, so the result is offered from the
// next cycle on; a load item in range writes one descriptor at acceptance and
// gives no result. The input side keeps accepting while the output register
// drains in the same cycle, and stalls only while a result waits on m_tready.
// Depends on trcg_pkg.
module tristate_remote_code_generator #(
    parameter int SYMBOLS_PER_FRAME = trcg_pkg::SYMBOLS_PER_FRAME_DEF,
    parameter int FRAMES            = trcg_pkg::FRAMES_DEF,
    parameter int CHANNELS          = trcg_pkg::CHANNELS_DEF,
    parameter int MAX_CODE_SYMBOLS  = trcg_pkg::MAX_CODE_SYMBOLS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // channel[1:0], frame[3:2], code_mode[5:4], code_length[9:6],
    // code_word[33:10], zero[39:34]
    input  logic [trcg_pkg::S_TDATA_W-1:0]      s_tdata,
    // mode: 0 tick, 1 load
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // bus_level[3:0], zero[7:4]
    output logic [trcg_pkg::M_TDATA_W-1:0]      m_tdata,
    // cycle_end
    output logic                                m_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [trcg_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [trcg_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [trcg_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import trcg_pkg::*;

    // only channels 0..3 can be loaded and reach the bus
    localparam int LANES   = (CHANNELS < BUS_W) ? CHANNELS : BUS_W;
    localparam int LANE_W  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int SYM_W   = $clog2(SYMBOLS_PER_FRAME);
    localparam int EFF_MAX = (MAX_CODE_SYMBOLS < SYMBOLS_PER_FRAME) ?
                             MAX_CODE_SYMBOLS : SYMBOLS_PER_FRAME;
    localparam int CMP_W   = 6;

    logic [BUS_W-1:0]   enable_reg;
    logic [BUS_W-1:0]   force_reg;
    logic               cfg_wr;

    desc_t              desc_reg [LANES][FRAMES];

    logic [SUB_W-1:0]   sub_reg;
    logic [SYM_W-1:0]   sym_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic               last_sub;
    logic               last_sym;
    logic               last_frame;
    logic               last_slot;

    logic               m_tvalid_reg;
    logic [BUS_W-1:0]   level_reg;
    logic               cycle_end_reg;
    logic [BUS_W-1:0]   level_next;

    logic               in_acc;
    logic               tick_acc;
    logic               load_acc;

    logic [1:0]         ld_channel;
    logic [1:0]         ld_frame;
    desc_t              ld_desc;
    logic               ld_in_range;

    desc_t              rd_desc  [LANES];
    logic [LEN_W-1:0]   len_eff  [LANES];
    logic [WORD_W-1:0]  word_sh  [LANES];
    logic [BUS_W-1:0]   raw_level;

    logic [CMP_W-1:0]   sym_ext;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= ENABLE_RST;
            force_reg  <= FORCE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_ENABLE: enable_reg <= pwdata[BUS_W-1:0];
                REG_FORCE:  force_reg  <= pwdata[BUS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ENABLE: prdata = APB_DATA_W'(enable_reg);
            REG_FORCE:  prdata = APB_DATA_W'(force_reg);
            default:    prdata = '0;
        endcase
    end

    // ---------------- input handshake ----------------
    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign tick_acc = in_acc && (s_tuser == KIND_TICK);
    assign load_acc = in_acc && (s_tuser == KIND_LOAD);

    assign ld_channel          = s_tdata[1:0];
    assign ld_frame            = s_tdata[3:2];
    assign ld_desc.code_mode   = s_tdata[5:4];
    assign ld_desc.code_length = s_tdata[9:6];
    assign ld_desc.code_word   = s_tdata[33:10];
    assign ld_in_range = (32'(ld_channel) < 32'(LANES)) && (32'(ld_frame) < 32'(FRAMES));

    always_ff @(posedge aclk) begin
        if (load_acc && ld_in_range) begin
            desc_reg[LANE_W'(ld_channel)][FRAME_W'(ld_frame)] <= ld_desc;
        end
    end

    // ---------------- slot position ----------------
    assign last_sub   = (sub_reg == SUB_W'(SLOTS_PER_SYMBOL - 1));
    assign last_sym   = (sym_reg == SYM_W'(SYMBOLS_PER_FRAME - 1));
    assign last_frame = (frame_reg == FRAME_W'(FRAMES - 1));
    assign last_slot  = last_sub && last_sym && last_frame;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg   <= '0;
            sym_reg   <= '0;
            frame_reg <= '0;
        end else if (tick_acc) begin
            sub_reg <= sub_reg + 1'b1;
            if (last_sub) begin
                if (last_sym) begin
                    sym_reg   <= '0;
                    frame_reg <= last_frame ? '0 : frame_reg + 1'b1;
                end else begin
                    sym_reg <= sym_reg + 1'b1;
                end
            end
        end
    end

    // ---------------- per-channel level ----------------
    assign sym_ext = CMP_W'(sym_reg);

    always_comb begin
        raw_level = '0;
        for (int l = 0; l < LANES; l++) begin
            rd_desc[l] = desc_reg[l][frame_reg];
            len_eff[l] = (32'(rd_desc[l].code_length) > EFF_MAX) ?
                         LEN_W'(EFF_MAX) : rd_desc[l].code_length;
            // symbols past the word shift out as zero
            word_sh[l] = rd_desc[l].code_word >> {sym_ext, 1'b0};
            if (sym_ext < CMP_W'(len_eff[l])) begin
                case (rd_desc[l].code_mode)
                    CM_TRISTATE:    raw_level[l] = TRI_PATTERN[word_sh[l][1:0]][sub_reg];
                    CM_SLOT_SQUARE: raw_level[l] = sub_reg[0];
                    default:        raw_level[l] = sub_reg[1];
                endcase
            end else begin
                // sync slot right after the code; dropped if past frame end
                raw_level[l] = (rd_desc[l].code_mode == CM_TRISTATE) &&
                               (sym_ext == CMP_W'(len_eff[l])) && (sub_reg == '0);
            end
        end
    end

    assign level_next = (raw_level & enable_reg) | force_reg;

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (tick_acc) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_acc) begin
            level_reg     <= level_next;
            cycle_end_reg <= last_slot;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(level_reg);
    assign m_tlast  = cycle_end_reg;

`ifndef SYNTHESIS
    a_wrap_to_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_acc && last_slot |=> sub_reg == '0 && sym_reg == '0 && frame_reg == '0)
        else $error("slot position did not wrap at cycle end");

    a_load_keeps_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        load_acc |=> $stable(sub_reg) && $stable(sym_reg) && $stable(frame_reg))
        else $error("load item moved the slot position");

    a_frame_range: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_reg <= FRAME_W'(FRAMES - 1))
        else $error("frame counter out of range");

    a_tick_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_acc |=> m_tvalid_reg)
        else $error("tick item gave no result");
`endif

endmodule
